FILE: hdl/twr_pkg.sv
// ----------------------------------------------------------------------------
// twr_pkg: shared constants for the ranging core
// Field widths, history geometry and register indexes.
// ----------------------------------------------------------------------------
package twr_pkg;

  // anchors and history depth; HIST_LEN is a power of two
  localparam int NUM_ANCHORS = 8;
  localparam int HIST_LEN    = 32;
  localparam int ANC_W       = $clog2(NUM_ANCHORS);
  localparam int IDX_W       = $clog2(HIST_LEN);
  localparam int CNT_W       = IDX_W + 2;
  localparam int ADDR_W      = ANC_W + IDX_W;

  // field widths
  localparam int ANCHOR_W = 3;
  localparam int TS_W     = 32;
  localparam int DIST_W   = 21;
  localparam int SCALE_W  = 20;
  localparam int FACT_W   = 4;
  localparam int CFG_W    = 20;

  // serial datapath widths
  localparam int PROD_W = 2 * TS_W;        // interval products
  localparam int MUL_W  = PROD_W + TS_W;   // serial multiplier result
  localparam int SUMT_W = TS_W + 2;        // sum of four intervals
  localparam int NUM_W  = PROD_W + SCALE_W - 16;
  localparam int QUO_W  = DIST_W + 1;

  // gate statistics widths
  localparam int SUM_W  = DIST_W + IDX_W;
  localparam int SQ_W   = 2 * DIST_W + IDX_W;
  localparam int DIFF_W = SUM_W + 1;
  localparam int LHS_W  = 2 * DIFF_W + IDX_W;
  localparam int VAR_W  = SQ_W + IDX_W;
  localparam int KK_W   = 2 * FACT_W;
  localparam int RHS_W  = VAR_W + IDX_W + KK_W;

  // saturation limits of the distance magnitude
  localparam logic [DIST_W-1:0] DIST_MAX     = DIST_W'((1 << (DIST_W - 1)) - 1);
  localparam logic [DIST_W-1:0] DIST_MIN_MAG = DIST_W'(1 << (DIST_W - 1));

  // configuration register indexes and reset values
  localparam logic REG_SCALE  = 1'b0;
  localparam logic REG_FACTOR = 1'b1;
  localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(307479);
  localparam logic [FACT_W-1:0]  FACTOR_RESET = FACT_W'(4);

endpackage

FILE: hdl/twr_mul_serial.sv
// ----------------------------------------------------------------------------
// twr_mul_serial: bit-serial shift-add multiplier
// One multiplier bit per cycle.
// ----------------------------------------------------------------------------
module twr_mul_serial import twr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] a,
  input  logic [TS_W-1:0]   b,
  output logic              done,
  output logic [MUL_W-1:0]  product
);

  logic [PROD_W-1:0] a_q;
  logic [PROD_W-1:0] hi;
  logic [TS_W-1:0]   lo;
  logic [$clog2(TS_W)-1:0] cnt;
  logic              busy;
  logic [PROD_W:0]   sum;

  // add the multiplicand when the low bit is set
  assign sum     = {1'b0, hi} + (lo[0] ? {1'b0, a_q} : '0);
  assign product = {hi, lo};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == $clog2(TS_W)'(TS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift the partial product right one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      hi  <= '0;
      lo  <= b;
    end else if (busy) begin
      hi <= sum[PROD_W:1];
      lo <= {sum[0], lo[TS_W-1:1]};
    end
  end

endmodule

FILE: hdl/twr_div_serial.sv
// ----------------------------------------------------------------------------
// twr_div_serial: restoring divider with saturation
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module twr_div_serial import twr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [SUMT_W-1:0] den,
  input  logic [DIST_W-1:0] limit,
  output logic              done,
  output logic [DIST_W-1:0] quo
);

  logic [NUM_W-1:0]  n;
  logic [SUMT_W-1:0] d;
  logic [SUMT_W-1:0] rem;
  logic [QUO_W-1:0]  q;
  logic [DIST_W-1:0] lim;
  logic              ovf;
  logic              busy;
  logic [$clog2(NUM_W)-1:0] cnt;
  logic [SUMT_W:0]   r2;
  logic              ge;
  logic [SUMT_W:0]   diff;

  // trial subtract
  assign r2   = {rem, n[NUM_W-1]};
  assign ge   = r2 >= {1'b0, d};
  assign diff = r2 - {1'b0, d};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == $clog2(NUM_W)'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift in one numerator bit, track quotient overflow
  always_ff @(posedge clk) begin
    if (start) begin
      n   <= num;
      d   <= den;
      lim <= limit;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      n   <= {n[NUM_W-2:0], 1'b0};
      rem <= ge ? diff[SUMT_W-1:0] : r2[SUMT_W-1:0];
      q   <= {q[QUO_W-2:0], ge};
      ovf <= ovf | q[QUO_W-1];
    end
  end

  // saturate to the limit
  assign quo = (ovf || q > {1'b0, lim}) ? lim : q[DIST_W-1:0];

endmodule

FILE: hdl/twr_gate.sv
// ----------------------------------------------------------------------------
// twr_gate: per-anchor history and outlier test
// Walks one history entry per cycle, then tests the new distance on squares.
// ----------------------------------------------------------------------------
module twr_gate import twr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ANC_W-1:0]         anchor,
  input  logic signed [DIST_W-1:0] range_mm,
  input  logic [FACT_W-1:0]        factor,
  output logic                     busy,
  output logic                     done,
  output logic                     pass
);

  localparam logic [2:0] G_IDLE = 3'd0;
  localparam logic [2:0] G_RUN  = 3'd1;
  localparam logic [2:0] G_C1   = 3'd2;
  localparam logic [2:0] G_C2   = 3'd3;
  localparam logic [2:0] G_C3   = 3'd4;
  localparam logic [2:0] G_C4   = 3'd5;
  localparam logic [2:0] G_C5   = 3'd6;

  localparam int DEPTH = NUM_ANCHORS * HIST_LEN;

  logic [2:0]               state;
  logic [CNT_W-1:0]         cnt;
  logic [ANC_W-1:0]         anc;
  logic signed [DIST_W-1:0] d_q;
  logic [FACT_W-1:0]        k_q;
  logic [IDX_W-1:0]         slot_tab [NUM_ANCHORS];
  logic [IDX_W-1:0]         new_slot;
  logic [DIST_W-1:0]        mem [DEPTH];
  logic [DEPTH-1:0]         hvalid;
  logic [DIST_W-1:0]        mem_q;
  logic                     hv_q;
  logic                     v1, v2;
  logic signed [DIST_W-1:0] val1, val2;
  logic [DIST_W-1:0]        mag1;
  logic [2*DIST_W-1:0]      sq2;
  logic signed [SUM_W-1:0]  sum;
  logic [SQ_W-1:0]          sumsq;
  logic [DIFF_W-1:0]        diff;
  logic [SUM_W-1:0]         sum_mag;
  logic [2*DIFF_W-1:0]      diff2;
  logic [2*SUM_W-1:0]       sum2;
  logic [LHS_W-1:0]         lhs;
  logic [VAR_W-1:0]         var_q;
  logic [KK_W-1:0]          kk;
  logic [RHS_W-1:0]         rhs;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     rd_en;
  logic signed [DIFF_W-1:0] dev;
  logic [IDX_W-1:0]         cur_slot;

  assign busy     = state != G_IDLE;
  assign rd_en    = state == G_RUN && cnt < CNT_W'(HIST_LEN);
  assign rd_addr  = {anc, cnt[IDX_W-1:0]};
  assign val1     = hv_q ? $signed(mem_q) : '0;
  assign mag1     = val1[DIST_W-1] ? DIST_W'(-val1) : DIST_W'(val1);
  assign dev      = DIFF_W'(sum) - (DIFF_W'(d_q) <<< IDX_W);
  assign cur_slot = slot_tab[anchor];

  // history read, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      hv_q  <= hvalid[rd_addr];
    end
  end

  // history write of the new distance
  always_ff @(posedge clk) begin
    if (state == G_C5) begin
      mem[{anc, new_slot}] <= d_q;
    end
  end

  // valid bits and slot pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
      for (int i = 0; i < NUM_ANCHORS; i++) begin
        slot_tab[i] <= '0;
      end
    end else begin
      if (start) begin
        slot_tab[anchor] <= (cur_slot == IDX_W'(HIST_LEN - 1)) ? '0 : cur_slot + 1'b1;
      end
      if (state == G_C5) begin
        hvalid[{anc, new_slot}] <= 1'b1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      cnt   <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      v1   <= rd_en;
      v2   <= v1;
      case (state)
        G_IDLE: begin
          if (start) begin
            state <= G_RUN;
            cnt   <= '0;
          end
        end
        G_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(HIST_LEN + 2)) begin
            state <= G_C1;
          end
        end
        G_C1: state <= G_C2;
        G_C2: state <= G_C3;
        G_C3: state <= G_C4;
        G_C4: state <= G_C5;
        G_C5: begin
          state <= G_IDLE;
          done  <= 1'b1;
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  // operands, statistics and the square-domain compare
  always_ff @(posedge clk) begin
    if (start) begin
      anc      <= anchor;
      d_q      <= range_mm;
      k_q      <= factor;
      new_slot <= (cur_slot == IDX_W'(HIST_LEN - 1)) ? '0 : cur_slot + 1'b1;
      sum      <= '0;
      sumsq    <= '0;
    end else begin
      if (v1) begin
        val2 <= val1;
        sq2  <= mag1 * mag1;
      end
      if (v2) begin
        sum   <= sum + SUM_W'(val2);
        sumsq <= sumsq + SQ_W'(sq2);
      end
      case (state)
        G_C1: begin
          diff    <= dev[DIFF_W-1] ? DIFF_W'(-dev) : DIFF_W'(dev);
          sum_mag <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
          kk      <= k_q * k_q;
        end
        G_C2: begin
          diff2 <= diff * diff;
          sum2  <= sum_mag * sum_mag;
        end
        G_C3: begin
          lhs   <= (LHS_W'(diff2) << IDX_W) - LHS_W'(diff2);
          var_q <= (VAR_W'(sumsq) << IDX_W) - VAR_W'(sum2);
        end
        G_C4: rhs <= (RHS_W'(var_q) << IDX_W) * RHS_W'(kk);
        G_C5: pass <= RHS_W'(lhs) < rhs;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/twr_range_with_outlier_gate_core.sv
// ----------------------------------------------------------------------------
// twr_range_with_outlier_gate_core: two-way ranging distance with outlier gate
//
//   channel | signals                          | transfer when
//   input   | in_valid, in_ready, fields       | in_valid & in_ready
//   output  | out_valid, out_ready, fields     | out_valid & out_ready
//   config  | cfg_we, cfg_index, cfg_data      | cfg_we
//
// After the input transfer an item passes the two interval products, the
// tick-to-millimetre scale, the serial divide and the history walk and test,
// and is then loaded into the output register.
// With all four intervals zero the scale and divide are skipped.
// Items are worked one at a time and the input is ready only in idle; a new one
// is taken while the result waits, and a second result stalls while the output is full.
// Reset clears the history at once through per-entry valid bits.
// ----------------------------------------------------------------------------
module twr_range_with_outlier_gate_core import twr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ANCHOR_W-1:0]      anchor_index,
  input  logic [TS_W-1:0]          poll_sent,
  input  logic [TS_W-1:0]          poll_heard,
  input  logic [TS_W-1:0]          answer_sent,
  input  logic [TS_W-1:0]          answer_heard,
  input  logic [TS_W-1:0]          final_sent,
  input  logic [TS_W-1:0]          final_heard,
  input  logic                     position_known,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ANCHOR_W-1:0]      anchor_out,
  output logic signed [DIST_W-1:0] distance_mm,
  output logic                     accepted,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROD  = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_GATE  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]               state;
  logic [SCALE_W-1:0]       scale;
  logic [FACT_W-1:0]        factor;
  logic [ANCHOR_W-1:0]      anc_q;
  logic                     pos_q;
  logic [TS_W-1:0]          ra, da, rb, db;
  logic [SUMT_W-1:0]        s_q;
  logic [PROD_W-1:0]        mag;
  logic                     neg;
  logic signed [DIST_W-1:0] range_mm;
  logic                     anc_ok;
  logic                     pass_q;
  logic                     mul_start, div_start, gate_start;
  logic                     mul0_done, mul1_done, div_done, gate_done, gate_busy, gate_pass;
  logic [MUL_W-1:0]         prod0, prod1;
  logic [PROD_W-1:0]        mul0_a;
  logic [TS_W-1:0]          mul0_b;
  logic [DIST_W-1:0]        quo;
  logic                     out_load;

  assign in_ready = state == S_IDLE;
  assign out_load = state == S_OUT && (!out_valid || out_ready);
  assign anc_ok   = {1'b0, anc_q} < (ANCHOR_W + 1)'(NUM_ANCHORS);
  assign mul0_a   = state == S_SCALE ? mag : PROD_W'(ra);
  assign mul0_b   = state == S_SCALE ? TS_W'(scale) : rb;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale  <= SCALE_RESET;
      factor <= FACTOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE:  scale  <= cfg_data[SCALE_W-1:0];
        REG_FACTOR: factor <= cfg_data[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  twr_mul_serial u_mul0 (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul0_a), .b(mul0_b),
    .done(mul0_done), .product(prod0)
  );

  twr_mul_serial u_mul1 (
    .clk(clk), .rst(rst), .start(mul_start && state == S_PROD),
    .a(PROD_W'(da)), .b(db), .done(mul1_done), .product(prod1)
  );

  twr_div_serial u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(prod0[NUM_W+15:16]),
    .den(s_q), .limit(neg ? DIST_MIN_MAG : DIST_MAX), .done(div_done), .quo(quo)
  );

  twr_gate u_gate (
    .clk(clk), .rst(rst), .start(gate_start), .anchor(anc_q[ANC_W-1:0]),
    .range_mm(range_mm), .factor(factor), .busy(gate_busy), .done(gate_done),
    .pass(gate_pass)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mul_start  <= 1'b0;
      div_start  <= 1'b0;
      gate_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      mul_start  <= 1'b0;
      div_start  <= 1'b0;
      gate_start <= 1'b0;
      // load a new result or drop the one just transferred
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state     <= S_PROD;
            mul_start <= 1'b1;
          end
        end
        S_PROD: begin
          if (mul0_done && mul1_done) begin
            if (s_q == '0) begin
              state      <= anc_ok ? S_GATE : S_OUT;
              gate_start <= anc_ok;
            end else begin
              state     <= S_SCALE;
              mul_start <= 1'b1;
            end
          end
        end
        S_SCALE: begin
          if (mul0_done) begin
            state     <= S_DIV;
            div_start <= 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state      <= anc_ok ? S_GATE : S_OUT;
            gate_start <= anc_ok;
          end
        end
        S_GATE: begin
          if (gate_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      anc_q    <= anchor_index;
      pos_q    <= position_known;
      ra       <= answer_heard - poll_sent;
      da       <= answer_sent - poll_heard;
      rb       <= final_heard - answer_sent;
      db       <= final_sent - answer_heard;
      range_mm <= '0;
      pass_q   <= 1'b0;
    end
    if (state == S_PROD && mul0_done) begin
      neg <= prod0[PROD_W-1:0] < prod1[PROD_W-1:0];
      mag <= (prod0[PROD_W-1:0] < prod1[PROD_W-1:0]) ?
             prod1[PROD_W-1:0] - prod0[PROD_W-1:0] : prod0[PROD_W-1:0] - prod1[PROD_W-1:0];
    end
    if (state == S_PROD && mul_start) begin
      s_q <= SUMT_W'(ra) + SUMT_W'(rb) + SUMT_W'(da) + SUMT_W'(db);
    end
    if (state == S_DIV && div_done) begin
      range_mm <= neg ? $signed(-quo) : $signed(quo);
    end
    if (state == S_GATE && gate_done) begin
      pass_q <= gate_pass;
    end
    if (out_load) begin
      anchor_out  <= anc_q;
      distance_mm <= range_mm;
      accepted    <= pass_q && pos_q;
    end
  end

`ifndef SYNTH
  // no item enters while the history walk is running
  a_gate_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !gate_busy)
    else $error("item taken while gate busy");

  // an accepted result needs a known anchor position
  a_acc_pos: assert property (@(posedge clk) disable iff (rst)
    out_load |=> !accepted || $past(pos_q))
    else $error("accepted without known position");

  // the divider only finishes while the sequencer waits for it
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider result outside divide phase");
`endif

endmodule
